// ----- sv/tbae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbae_pkg
// Shared types and constants for the two-background alpha extractor.
// ----------------------------------------------------------------------------
package tbae_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BLACK_OPAQUE   = 3'd0;
  localparam logic [2:0] CFG_MIN_ALPHA      = 3'd1;
  localparam logic [2:0] CFG_CLIP_ENABLE    = 3'd2;
  localparam logic [2:0] CFG_MONITOR_COUNT  = 3'd3;
  localparam logic [2:0] CFG_MONITOR0_RECT  = 3'd4;
  localparam logic [2:0] CFG_MONITOR1_RECT  = 3'd5;
  localparam logic [2:0] CFG_CAPTURE_ORIGIN = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Monitor counts with a special meaning.
  localparam logic [1:0] MON_NONE   = 2'd0;
  localparam logic [1:0] MON_SINGLE = 2'd1;

  // Alpha arithmetic.
  localparam logic [7:0]  ALPHA_FULL = 8'd255;
  localparam logic [7:0]  ALPHA_ZERO = 8'd0;
  localparam logic [11:0] SUM_BIAS   = 12'd765;
  // Division by three: x * 683 >> 11 is exact for x below 1531.
  localparam logic [9:0]  DIV3_MUL   = 10'd683;
  localparam int          DIV3_SHIFT = 11;

  // Rectangle packing: left in the low half-word, bottom in the high one.
  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } rect_t;

  typedef struct packed {
    logic               black_opaque;
    logic [7:0]         min_alpha;
    logic               clip_enable;
    logic [1:0]         monitor_count;
    rect_t              rect0;
    rect_t              rect1;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_x;
  } cfg_t;

  // First stage: screen position, channel sum and scaled black values.
  typedef struct packed {
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic [10:0]        sum;
    logic [7:0]         white_r;
    logic [7:0]         white_g;
    logic [7:0]         white_b;
    logic [7:0]         white_a;
    logic [15:0]        n_r;
    logic [15:0]        n_g;
    logic [15:0]        n_b;
  } front_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  quo;
    logic        ovf;
  } div_lane_t;

  // Payload of the divider stages.
  typedef struct packed {
    logic [7:0]           alpha;
    logic [7:0]           white_r;
    logic [7:0]           white_g;
    logic [7:0]           white_b;
    logic [7:0]           white_a;
    div_lane_t [2:0]      lane;
  } pix_t;

  // One quotient bit of a restoring division.
  function automatic div_lane_t div_bit(div_lane_t l, logic [7:0] d, logic [2:0] j);
    div_lane_t   o;
    logic [15:0] dsh;
    o   = l;
    dsh = {8'b0, d} << j;
    if (l.rem >= dsh) begin
      o.rem    = l.rem - dsh;
      o.quo[j] = 1'b1;
    end
    return o;
  endfunction

endpackage

// ----- sv/tbae_inside.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbae_inside
// Monitor rectangle test of one screen position.
// ----------------------------------------------------------------------------
module tbae_inside (
  input  tbae_pkg::cfg_t      cfg,
  input  logic signed [16:0]  sx,
  input  logic signed [16:0]  sy,
  output logic                covered
);
  import tbae_pkg::*;

  logic hit0;
  logic hit1;

  // Half-open containment against both rectangles.
  always_comb begin
    hit0 = (sx >= 17'(cfg.rect0.left)) && (sx < 17'(cfg.rect0.right)) &&
           (sy >= 17'(cfg.rect0.top))  && (sy < 17'(cfg.rect0.bottom));
    hit1 = (sx >= 17'(cfg.rect1.left)) && (sx < 17'(cfg.rect1.right)) &&
           (sy >= 17'(cfg.rect1.top))  && (sy < 17'(cfg.rect1.bottom));
  end

  // Clipping off or a single monitor covers everything; no monitor covers nothing.
  always_comb begin
    priority if (!cfg.clip_enable || cfg.monitor_count == MON_SINGLE) begin
      covered = 1'b1;
    end else if (cfg.monitor_count == MON_NONE) begin
      covered = 1'b0;
    end else begin
      covered = hit0 || hit1;
    end
  end

endmodule

// ----- sv/two_background_alpha_extract_top.sv -----
`timescale 1ns / 1ps
// An accepted input beat passes front_r, stg_r[2..6] and the output registers.
// Throughput: one pixel per cycle while out_stall is low; the restoring divider is
// spread over five stages, one or two quotient bits per stage, so nothing iterates.
// Each stage advances when empty or when the stage after it advances.
// Reset: synchronous, active low; clears the valid bits and the configuration
// registers; the data path registers are not reset.
// ----------------------------------------------------------------------------
// two_background_alpha_extract_top
// Difference matting: alpha and un-premultiplied color from a pixel shot
// over white and over black, with monitor rectangle clipping.
// ----------------------------------------------------------------------------
module two_background_alpha_extract_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_white_r,
  input  logic [7:0]  in_white_g,
  input  logic [7:0]  in_white_b,
  input  logic [7:0]  in_white_a,
  input  logic [7:0]  in_black_r,
  input  logic [7:0]  in_black_g,
  input  logic [7:0]  in_black_b,
  input  logic [13:0] in_pos_x,
  input  logic [13:0] in_pos_y,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_a,
  output logic [7:0]  out_r,
  output logic [7:0]  out_g,
  output logic [7:0]  out_b
);
  import tbae_pkg::*;

  cfg_t        cfg_r;
  logic [7:1]  v_r;
  logic [8:1]  en;
  front_t      front_r;
  front_t      front_nxt;
  pix_t        stg_r   [2:6];
  pix_t        stg_nxt [2:6];
  logic [7:0]  out_a_r, out_r_r, out_g_r, out_b_r;
  logic [7:0]  out_a_nxt, out_r_nxt, out_g_nxt, out_b_nxt;
  logic        covered;
  logic [20:0] div3_prod;
  logic [9:0]  alpha_raw;
  logic [11:0] sum_wide;
  div_lane_t   last_lane [2:0];
  logic [7:0]  col [2:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLACK_OPAQUE:   cfg_r.black_opaque  <= cfg_data[0];
        CFG_MIN_ALPHA:      cfg_r.min_alpha     <= cfg_data[7:0];
        CFG_CLIP_ENABLE:    cfg_r.clip_enable   <= cfg_data[0];
        CFG_MONITOR_COUNT:  cfg_r.monitor_count <= cfg_data[1:0];
        CFG_MONITOR0_RECT:  cfg_r.rect0         <= cfg_data;
        CFG_MONITOR1_RECT:  cfg_r.rect1         <= cfg_data;
        CFG_CAPTURE_ORIGIN: begin
          cfg_r.origin_x <= cfg_data[15:0];
          cfg_r.origin_y <= cfg_data[31:16];
        end
        default: ;
      endcase
    end
  end

  // Stall chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[8] = !out_stall;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[7];

  // Stage 1: screen position, biased channel sum and 255 * black.
  always_comb begin
    front_nxt.sx = $signed({3'b0, in_pos_x}) + 17'(cfg_r.origin_x);
    front_nxt.sy = $signed({3'b0, in_pos_y}) + 17'(cfg_r.origin_y);
    sum_wide = SUM_BIAS + 12'(in_black_r) + 12'(in_black_g) + 12'(in_black_b)
               - 12'(in_white_r) - 12'(in_white_g) - 12'(in_white_b);
    front_nxt.sum     = sum_wide[10:0];
    front_nxt.white_r = in_white_r;
    front_nxt.white_g = in_white_g;
    front_nxt.white_b = in_white_b;
    front_nxt.white_a = in_white_a;
    front_nxt.n_r     = {in_black_r, 8'b0} - 16'(in_black_r);
    front_nxt.n_g     = {in_black_g, 8'b0} - 16'(in_black_g);
    front_nxt.n_b     = {in_black_b, 8'b0} - 16'(in_black_b);
  end

  // Stage 2: clip test and alpha as the capped mean.
  tbae_inside u_inside (
    .cfg     (cfg_r),
    .sx      (front_r.sx),
    .sy      (front_r.sy),
    .covered (covered)
  );

  assign div3_prod = 21'(front_r.sum) * 21'(DIV3_MUL);
  assign alpha_raw = div3_prod[20:DIV3_SHIFT];

  always_comb begin
    stg_nxt[2].white_r = front_r.white_r;
    stg_nxt[2].white_g = front_r.white_g;
    stg_nxt[2].white_b = front_r.white_b;
    stg_nxt[2].white_a = front_r.white_a;
    if (!covered) begin
      stg_nxt[2].alpha = ALPHA_ZERO;
    end else if (alpha_raw > 10'(ALPHA_FULL)) begin
      stg_nxt[2].alpha = ALPHA_FULL;
    end else begin
      stg_nxt[2].alpha = alpha_raw[7:0];
    end
    stg_nxt[2].lane[0] = '{rem: front_r.n_r, quo: 8'd0, ovf: 1'b0};
    stg_nxt[2].lane[1] = '{rem: front_r.n_g, quo: 8'd0, ovf: 1'b0};
    stg_nxt[2].lane[2] = '{rem: front_r.n_b, quo: 8'd0, ovf: 1'b0};
  end

  // Stage 3: quotient overflow check, then quotient bit 7.
  always_comb begin
    stg_nxt[3] = stg_r[2];
    for (int c = 0; c < 3; c++) begin
      stg_nxt[3].lane[c].ovf = stg_r[2].lane[c].rem >= {stg_r[2].alpha, 8'b0};
      stg_nxt[3].lane[c]     = div_bit(stg_nxt[3].lane[c], stg_r[2].alpha, 3'd7);
    end
  end

  // Stages 4 to 6: two quotient bits each.
  for (genvar k = 4; k <= 6; k++) begin : g_div
    always_comb begin
      stg_nxt[k] = stg_r[k-1];
      for (int c = 0; c < 3; c++) begin
        stg_nxt[k].lane[c] = div_bit(stg_nxt[k].lane[c], stg_r[k-1].alpha,
                                     3'(14 - 2 * k));
        stg_nxt[k].lane[c] = div_bit(stg_nxt[k].lane[c], stg_r[k-1].alpha,
                                     3'(13 - 2 * k));
      end
    end
  end

  // Stage 7: last quotient bit, saturation and output selection.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      last_lane[c] = div_bit(stg_r[6].lane[c], stg_r[6].alpha, 3'd0);
      col[c]       = last_lane[c].ovf ? 8'd255 : last_lane[c].quo;
    end
    out_a_nxt = 8'd0;
    out_r_nxt = 8'd0;
    out_g_nxt = 8'd0;
    out_b_nxt = 8'd0;
    priority if (cfg_r.black_opaque) begin
      out_a_nxt = (stg_r[6].alpha > cfg_r.min_alpha) ? ALPHA_FULL : ALPHA_ZERO;
    end else if (stg_r[6].alpha == ALPHA_FULL) begin
      out_a_nxt = stg_r[6].white_a;
      out_r_nxt = stg_r[6].white_r;
      out_g_nxt = stg_r[6].white_g;
      out_b_nxt = stg_r[6].white_b;
    end else if (stg_r[6].alpha != ALPHA_ZERO) begin
      out_a_nxt = stg_r[6].alpha;
      out_r_nxt = col[0];
      out_g_nxt = col[1];
      out_b_nxt = col[2];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      front_r <= front_nxt;
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (en[7]) begin
      out_a_r <= out_a_nxt;
      out_r_r <= out_r_nxt;
      out_g_r <= out_g_nxt;
      out_b_r <= out_b_nxt;
    end
  end

  assign out_a = out_a_r;
  assign out_r = out_r_r;
  assign out_g = out_g_r;
  assign out_b = out_b_r;

endmodule

// ----- bench/two_background_alpha_extract_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_background_alpha_extract_top_test
// Drives pixel pairs through the alpha extractor under several register
// settings and checks every output beat against a local prediction of alpha
// and color, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module two_background_alpha_extract_top_test;
  import tbae_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_PIXELS  = 50;

  // One pixel pair as it travels on the input channel.
  typedef struct packed {
    logic [7:0]  white_r;
    logic [7:0]  white_g;
    logic [7:0]  white_b;
    logic [7:0]  white_a;
    logic [7:0]  black_r;
    logic [7:0]  black_g;
    logic [7:0]  black_b;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
  } pixel_t;

  // One composite ARGB pixel on the result channel.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } composite_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_BLACK_OPAQUE;
  logic [63:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pixel_t      pixel_on_bus = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_a;
  logic [7:0]  out_r;
  logic [7:0]  out_g;
  logic [7:0]  out_b;

  pixel_t     pixel_queue[$];
  composite_t composite_queue[$];
  cfg_t       shadow_cfg = '0;
  int         cycle_count = 0;
  int         error_count = 0;
  logic       calm;

  two_background_alpha_extract_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_white_r (pixel_on_bus.white_r),
    .in_white_g (pixel_on_bus.white_g),
    .in_white_b (pixel_on_bus.white_b),
    .in_white_a (pixel_on_bus.white_a),
    .in_black_r (pixel_on_bus.black_r),
    .in_black_g (pixel_on_bus.black_g),
    .in_black_b (pixel_on_bus.black_b),
    .in_pos_x   (pixel_on_bus.pos_x),
    .in_pos_y   (pixel_on_bus.pos_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_a      (out_a),
    .out_r      (out_r),
    .out_g      (out_g),
    .out_b      (out_b)
  );

  always #5 clk = ~clk;

  // A recurring quiet window in which neither side idles.
  assign calm = (cycle_count % 1024) < 200;

  // Un-premultiply one channel, saturating at full scale.
  function automatic logic [7:0] unpremultiply(logic [7:0] c, int alpha);
    int q;
    q = (255 * int'(c)) / alpha;
    return (q > 255) ? ALPHA_FULL : q[7:0];
  endfunction

  // Composite pixel for one pair under the current register settings.
  function automatic composite_t predict_composite(pixel_t p);
    composite_t res;
    rect_t      rects[2];
    logic       covered;
    int         sx, sy, span, sum, alpha;
    res      = '0;
    rects[0] = shadow_cfg.rect0;
    rects[1] = shadow_cfg.rect1;
    if (!shadow_cfg.clip_enable || shadow_cfg.monitor_count == MON_SINGLE) begin
      covered = 1'b1;
    end else begin
      // Screen position at full precision; a count of three acts as two.
      sx      = int'(p.pos_x) + int'(shadow_cfg.origin_x);
      sy      = int'(p.pos_y) + int'(shadow_cfg.origin_y);
      span    = (shadow_cfg.monitor_count > 2) ? 2 : int'(shadow_cfg.monitor_count);
      covered = 1'b0;
      for (int i = 0; i < span; i++) begin
        if (sx >= rects[i].left && sx < rects[i].right &&
            sy >= rects[i].top && sy < rects[i].bottom) begin
          covered = 1'b1;
        end
      end
    end
    sum = int'(p.black_r) + 255 - int'(p.white_r) +
          int'(p.black_g) + 255 - int'(p.white_g) +
          int'(p.black_b) + 255 - int'(p.white_b);
    alpha = sum / 3;
    if (alpha > 255) alpha = 255;
    if (!covered) alpha = 0;
    if (shadow_cfg.black_opaque) begin
      res.a = (alpha > int'(shadow_cfg.min_alpha)) ? ALPHA_FULL : ALPHA_ZERO;
    end else if (alpha == 255) begin
      res = '{a: p.white_a, r: p.white_r, g: p.white_g, b: p.white_b};
    end else if (alpha > 0) begin
      res.a = alpha[7:0];
      res.r = unpremultiply(p.black_r, alpha);
      res.g = unpremultiply(p.black_g, alpha);
      res.b = unpremultiply(p.black_b, alpha);
    end
    return res;
  endfunction

  function automatic pixel_t make_pixel(int wr, int wg, int wb, int wa, int br, int bg,
                                        int bb, int x, int y);
    return '{white_r: 8'(wr), white_g: 8'(wg), white_b: 8'(wb), white_a: 8'(wa),
             black_r: 8'(br), black_g: 8'(bg), black_b: 8'(bb),
             pos_x: 14'(x), pos_y: 14'(y)};
  endfunction

  // White and black values of one channel that give exactly alpha a.
  function automatic logic [15:0] matte_pair(int a);
    int c, bv, wv;
    c  = $urandom_range(255);
    bv = (c * a) / 255;
    wv = bv + 255 - a;
    return {wv[7:0], bv[7:0]};
  endfunction

  // Mostly well-formed mattes with a share of raw noise.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     a;
    p.white_a = 8'($urandom);
    p.pos_x   = 14'($urandom);
    p.pos_y   = 14'($urandom);
    case ($urandom_range(9))
      0, 1, 2: begin
        p.white_r = 8'($urandom); p.white_g = 8'($urandom); p.white_b = 8'($urandom);
        p.black_r = 8'($urandom); p.black_g = 8'($urandom); p.black_b = 8'($urandom);
      end
      3: begin
        p.white_r = 8'($urandom); p.white_g = 8'($urandom); p.white_b = 8'($urandom);
        p.black_r = p.white_r; p.black_g = p.white_g; p.black_b = p.white_b;
      end
      4: begin
        p.white_r = 8'(255 - $urandom_range(2));
        p.white_g = 8'(255 - $urandom_range(2));
        p.white_b = 8'(255 - $urandom_range(2));
        p.black_r = 8'($urandom_range(2));
        p.black_g = 8'($urandom_range(2));
        p.black_b = 8'($urandom_range(2));
      end
      default: begin
        a = $urandom_range(255);
        {p.white_r, p.black_r} = matte_pair(a);
        {p.white_g, p.black_g} = matte_pair(a);
        {p.white_b, p.black_b} = matte_pair(a);
      end
    endcase
    return p;
  endfunction

  // Rectangle near the visible screen area, sometimes raw bits.
  function automatic logic [63:0] random_rect(int ox, int oy);
    int l, t, r, b;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    l = ox + int'($urandom_range(12000)) - 2000;
    t = oy + int'($urandom_range(12000)) - 2000;
    r = l + int'($urandom_range(14000)) - 500;
    b = t + int'($urandom_range(14000)) - 500;
    return {b[15:0], r[15:0], t[15:0], l[15:0]};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_BLACK_OPAQUE:   shadow_cfg.black_opaque  = data[0];
      CFG_MIN_ALPHA:      shadow_cfg.min_alpha     = data[7:0];
      CFG_CLIP_ENABLE:    shadow_cfg.clip_enable   = data[0];
      CFG_MONITOR_COUNT:  shadow_cfg.monitor_count = data[1:0];
      CFG_MONITOR0_RECT:  shadow_cfg.rect0         = data;
      CFG_MONITOR1_RECT:  shadow_cfg.rect1         = data;
      CFG_CAPTURE_ORIGIN: {shadow_cfg.origin_y, shadow_cfg.origin_x} = data[31:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic bo, logic [7:0] min_a, logic clip, logic [1:0] cnt,
                               logic [63:0] r0, logic [63:0] r1, logic [31:0] org);
    write_reg(CFG_BLACK_OPAQUE, {63'd0, bo});
    write_reg(CFG_MIN_ALPHA, {56'd0, min_a});
    write_reg(CFG_CLIP_ENABLE, {63'd0, clip});
    write_reg(CFG_MONITOR_COUNT, {62'd0, cnt});
    write_reg(CFG_MONITOR0_RECT, r0);
    write_reg(CFG_MONITOR1_RECT, r1);
    write_reg(CFG_CAPTURE_ORIGIN, {32'd0, org});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every beat produces a result, so an empty expectation store means idle.
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid || composite_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what, composite_t want, composite_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s at cycle %0d: expected a=%0d r=%0d g=%0d b=%0d, got a=%0d r=%0d g=%0d b=%0d",
               what, cycle_count, want.a, want.r, want.g, want.b, got.a, got.r, got.g, got.b);
    end
  endtask

  // Input driver: loads the next pixel when the bus slot frees up, with random gaps outside the calm window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        composite_queue.push_back(predict_composite(pixel_on_bus));
      end
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          pixel_on_bus <= pixel_queue.pop_front();
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    composite_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{a: out_a, r: out_r, g: out_g, b: out_b};
        if (composite_queue.size() == 0) begin
          report_mismatch("Unexpected beat", '0, got);
        end else if (composite_queue[0] != got) begin
          report_mismatch("Pixel mismatch", composite_queue.pop_front(), got);
        end else begin
          void'(composite_queue.pop_front());
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 27);
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic        bo, clip;
    logic [7:0]  min_a;
    logic [1:0]  cnt;
    logic [31:0] org;
    int          ox, oy;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Color mode at reset values: zero, full, partial, saturated, alpha 254 and 1.
    pixel_queue.push_back(make_pixel(255, 255, 255, 255, 0, 0, 0, 0, 0));
    pixel_queue.push_back(make_pixel(0, 0, 0, 8'hA5, 255, 255, 255, 14'h3FFF, 14'h3FFF));
    pixel_queue.push_back(make_pixel(8'h5A, 8'hC3, 8'h81, 8'h3C, 8'h5A, 8'hC3, 8'h81,
                                     14'h2AAA, 14'h1555));
    pixel_queue.push_back(make_pixel(200, 200, 200, 7, 50, 50, 50, 100, 200));
    pixel_queue.push_back(make_pixel(255, 255, 255, 0, 100, 0, 0, 1, 1));
    pixel_queue.push_back(make_pixel(255, 255, 255, 9, 254, 254, 254, 2, 3));
    pixel_queue.push_back(make_pixel(255, 255, 255, 9, 1, 1, 1, 4, 5));
    wait_drained();

    // Mask mode with the lowest threshold: alpha 0 stays clear, alpha 1 is opaque.
    apply_setting(1'b1, 8'd0, 1'b0, MON_NONE, '0, '0, '0);
    pixel_queue.push_back(make_pixel(255, 255, 255, 1, 0, 0, 0, 6, 7));
    pixel_queue.push_back(make_pixel(255, 255, 255, 1, 1, 1, 1, 8, 9));
    pixel_queue.push_back(make_pixel(10, 20, 30, 1, 10, 20, 30, 10, 11));
    wait_drained();

    // Mask mode with the highest threshold: never opaque.
    apply_setting(1'b1, 8'd255, 1'b0, MON_NONE, '0, '0, '0);
    pixel_queue.push_back(make_pixel(0, 0, 0, 1, 255, 255, 255, 12, 13));
    wait_drained();

    // Clipping with no monitors: everything is outside.
    apply_setting(1'b0, 8'd0, 1'b1, MON_NONE, '0, '0, '0);
    pixel_queue.push_back(make_pixel(0, 0, 0, 77, 255, 255, 255, 0, 0));
    pixel_queue.push_back(make_pixel(200, 200, 200, 7, 50, 50, 50, 50, 50));
    wait_drained();

    // A single monitor counts every pixel as inside, even with an empty rectangle.
    apply_setting(1'b0, 8'd0, 1'b1, MON_SINGLE, '0, '0, 32'h8000_8000);
    pixel_queue.push_back(make_pixel(0, 0, 0, 77, 255, 255, 255, 14'h3FFF, 0));
    wait_drained();

    // Two monitors, negative origin, edges of the first and an empty second one.
    ox = -100;
    oy = -50;
    org = {oy[15:0], ox[15:0]};
    apply_setting(1'b0, 8'd0, 1'b1, 2'd2,
                  {16'sd50, 16'sd100, -16'sd50, -16'sd100},
                  {16'sd1000, 16'sd400, 16'sd0, 16'sd500}, org);
    pixel_queue.push_back(make_pixel(0, 0, 0, 33, 255, 255, 255, 0, 0));
    pixel_queue.push_back(make_pixel(0, 0, 0, 33, 255, 255, 255, 199, 99));
    pixel_queue.push_back(make_pixel(0, 0, 0, 33, 255, 255, 255, 200, 0));
    pixel_queue.push_back(make_pixel(0, 0, 0, 33, 255, 255, 255, 700, 20));
    wait_drained();

    // A count of three behaves like two.
    write_reg(CFG_MONITOR_COUNT, 64'd3);
    @(posedge clk);
    cfg_we <= 1'b0;
    pixel_queue.push_back(make_pixel(0, 0, 0, 44, 255, 255, 255, 199, 99));
    pixel_queue.push_back(make_pixel(0, 0, 0, 44, 255, 255, 255, 0, 100));
    wait_drained();

    // Random phases, each with a fresh register setting.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      bo   = k[0];
      clip = (k % 3) != 0;
      cnt  = 2'($urandom_range(3));
      case ($urandom_range(3))
        0:       min_a = 8'd0;
        1:       min_a = 8'd255;
        default: min_a = 8'($urandom);
      endcase
      if ($urandom_range(3) == 0) begin
        org = $urandom;
        ox  = int'($signed(org[15:0]));
        oy  = int'($signed(org[31:16]));
      end else begin
        ox  = int'($urandom_range(8000)) - 4000;
        oy  = int'($urandom_range(8000)) - 4000;
        org = {oy[15:0], ox[15:0]};
      end
      apply_setting(bo, min_a, clip, cnt, random_rect(ox, oy), random_rect(ox, oy), org);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        pixel_queue.push_back(random_pixel());
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- two_background_alpha_extract_top.f -----
sv/tbae_pkg.sv
sv/tbae_inside.sv
sv/two_background_alpha_extract_top.sv
bench/two_background_alpha_extract_top_test.sv
